/* src/kmst_pkg.sv */
// ----------------------------------------------------------------------------
// kmst_pkg: shared types and constants for the Kruskal spanning tree block.
// Holds the vertex and weight sizing and the controller state encoding.
// ----------------------------------------------------------------------------
package kmst_pkg;
  localparam int MaxVertices = 16;
  localparam int WeightBits  = 16;
  localparam int VtxBits     = $clog2(MaxVertices);
  localparam int AddrBits    = 2 * VtxBits;
  localparam int CostBits    = 20;
  localparam int RankBits    = 3;
  localparam logic [WeightBits-1:0] NoneWeight = '1;
  localparam logic [RankBits-1:0]   RankMax    = '1;
  localparam logic [1:0] RegVertexCount = 2'd0;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_SCAN, ST_SCAN_END, ST_FIND_A, ST_FIND_B,
    ST_JOIN, ST_EMIT, ST_SUMMARY
  } kmst_state_e;
endpackage

/* src/kmst_weight_ram.sv */
// ----------------------------------------------------------------------------
// kmst_weight_ram: weight store with one write port and one registered read.
// Entries are addressed by row and column of the upper triangle.
// ----------------------------------------------------------------------------
module kmst_weight_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [kmst_pkg::AddrBits-1:0]   waddr_i,
  input  logic [kmst_pkg::WeightBits-1:0] wdata_i,
  input  logic [kmst_pkg::AddrBits-1:0]   raddr_i,
  output logic [kmst_pkg::WeightBits-1:0] rdata_o
);
  import kmst_pkg::*;
  logic [WeightBits-1:0] mem [2**AddrBits];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* src/kruskal_mst_matrix.sv */
// ----------------------------------------------------------------------------
// kruskal_mst_matrix: loads the upper triangle of a weight matrix, then finds a
// minimum spanning tree by Kruskal's method with union-find.
// ----------------------------------------------------------------------------
// Weight beats load back to back, one per cycle while in the load state, into the
// weight RAM. The last beat starts a run: an init step, then per round a scan of all
// n*n addresses, a step for the registered RAM read, a walk to each root, a join step
// and, for an accepted edge, an emit beat that waits on the output. A run has at most
// n(n-1)/2 rounds, one per edge considered, and ends with the summary beat. Reset (async,
// active low) clears the forest, controller and vertex count to 16; the RAM is kept.
module kruskal_mst_matrix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  row_vertex_i,
  input  logic [3:0]  col_vertex_i,
  input  logic [15:0] edge_weight_i,
  input  logic        last_weight_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        edge_valid_o,
  output logic [3:0]  edge_number_o,
  output logic [3:0]  end_a_o,
  output logic [3:0]  end_b_o,
  output logic [15:0] edge_cost_o,
  output logic [19:0] total_cost_o,
  output logic        spans_all_o,
  output logic        last_result_o
);
  import kmst_pkg::*;

  kmst_state_e state_q, state_d;
  logic [4:0] vcount_q;
  logic [VtxBits-1:0] n1_q;   // n-1, clamped, latched at run start
  logic [VtxBits-1:0] parent_q [MaxVertices];
  logic [RankBits-1:0] rank_q [MaxVertices];
  logic [VtxBits-1:0] cnt_q;
  logic [CostBits-1:0] sum_q;
  // Scan address and pipeline of the previous address for the RAM data.
  logic [VtxBits-1:0] si_q, sj_q, pi_q, pj_q;
  logic rd_ok_q;
  logic found_q;
  logic [WeightBits-1:0] best_q;
  logic [VtxBits-1:0] br_q, bc_q, ra_q, rb_q, walk_q;
  // Key of the edge picked in the previous round of this run.
  logic picked_q;
  logic [WeightBits-1:0] pick_w_q;
  logic [VtxBits-1:0] pick_r_q, pick_c_q;

  // Configuration port: the user must write only while idle; the block does not enforce it.
  assign pready = 1'b1;
  assign prdata = (paddr == RegVertexCount) ? {27'd0, vcount_q} : 32'd0;

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && (paddr == RegVertexCount);

  // Input swap and store.
  logic [VtxBits-1:0] lo_v, hi_v;
  logic in_fire;
  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire = in_valid_i && in_ready_o;
  assign lo_v = (row_vertex_i > col_vertex_i) ? col_vertex_i : row_vertex_i;
  assign hi_v = (row_vertex_i > col_vertex_i) ? row_vertex_i : col_vertex_i;

  logic [WeightBits-1:0] rdata;
  logic [AddrBits-1:0] raddr;
  assign raddr = {si_q, sj_q};

  kmst_weight_ram u_ram (
    .clk_i, .we_i(in_fire && (lo_v != hi_v)), .waddr_i({lo_v, hi_v}),
    .wdata_i(edge_weight_i), .raddr_i(raddr), .rdata_o(rdata)
  );

  // Candidate test on the data returned for the previous address. Picks come
  // out in strictly rising (weight, row, column) order, so an edge is still
  // unprocessed exactly when its key lies beyond the previous pick.
  logic cand, better, scan_last, past_pick;
  assign past_pick = !picked_q || ({rdata, pi_q, pj_q} > {pick_w_q, pick_r_q, pick_c_q});
  assign cand = rd_ok_q && (pi_q < pj_q) && (pj_q <= n1_q) && past_pick
                && (rdata != '0) && (rdata != NoneWeight);
  assign better = cand && (!found_q || rdata < best_q);
  assign scan_last = (si_q == n1_q) && (sj_q == n1_q);

  logic at_root;
  assign at_root = (parent_q[walk_q] == walk_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:     if (in_fire && last_weight_i) state_d = ST_INIT;
      ST_INIT:     state_d = (n1_q == '0) ? ST_SUMMARY : ST_SCAN;
      ST_SCAN:     if (scan_last) state_d = ST_SCAN_END;
      ST_SCAN_END: state_d = (found_q || better) ? ST_FIND_A : ST_SUMMARY;
      ST_FIND_A:   if (at_root) state_d = ST_FIND_B;
      ST_FIND_B:   if (at_root) state_d = ST_JOIN;
      ST_JOIN:     state_d = (ra_q != walk_q) ? ST_EMIT :
                             ((cnt_q == n1_q) ? ST_SUMMARY : ST_SCAN);
      ST_EMIT:     if (out_ready_i) state_d = (cnt_q == n1_q) ? ST_SUMMARY : ST_SCAN;
      ST_SUMMARY:  if (out_ready_i) state_d = ST_LOAD;
      default:     state_d = ST_LOAD;
    endcase
  end

  // Outputs.
  always_comb begin
    out_valid_o   = (state_q == ST_EMIT) || (state_q == ST_SUMMARY);
    edge_valid_o  = (state_q == ST_EMIT);
    edge_number_o = (state_q == ST_EMIT) ? cnt_q - 4'd1 : cnt_q;
    end_a_o       = (state_q == ST_EMIT) ? br_q : '0;
    end_b_o       = (state_q == ST_EMIT) ? bc_q : '0;
    edge_cost_o   = (state_q == ST_EMIT) ? best_q : '0;
    total_cost_o  = sum_q;
    spans_all_o   = (state_q == ST_SUMMARY) && (cnt_q == n1_q);
    last_result_o = (state_q == ST_SUMMARY);
  end

  logic [4:0] vclamp;
  always_comb begin
    vclamp = vcount_q;
    if (vclamp == 5'd0) vclamp = 5'd1;
    if (vclamp > 5'(MaxVertices)) vclamp = 5'(MaxVertices);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      vcount_q <= 5'd16;
      n1_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
      si_q <= '0; sj_q <= '0; pi_q <= '0; pj_q <= '0;
      rd_ok_q <= 1'b0;
      found_q <= 1'b0;
      best_q <= '0; br_q <= '0; bc_q <= '0;
      ra_q <= '0; rb_q <= '0; walk_q <= '0;
      picked_q <= 1'b0; pick_w_q <= '0; pick_r_q <= '0; pick_c_q <= '0;
      for (int k = 0; k < MaxVertices; k++) begin
        parent_q[k] <= VtxBits'(k);
        rank_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we) vcount_q <= pwdata[4:0];
      pi_q <= si_q; pj_q <= sj_q;
      rd_ok_q <= (state_q == ST_SCAN);
      case (state_q)
        ST_LOAD: if (in_fire && last_weight_i) n1_q <= VtxBits'(vclamp - 5'd1);
        ST_INIT: begin
          cnt_q <= '0; sum_q <= '0; picked_q <= 1'b0;
          si_q <= '0; sj_q <= '0; found_q <= 1'b0;
          for (int k = 0; k < MaxVertices; k++) begin
            parent_q[k] <= VtxBits'(k);
            rank_q[k] <= '0;
          end
        end
        ST_SCAN, ST_SCAN_END: begin
          if (better) begin
            found_q <= 1'b1; best_q <= rdata; br_q <= pi_q; bc_q <= pj_q;
          end
          if (state_q == ST_SCAN) begin
            if (sj_q == n1_q) begin
              sj_q <= '0; si_q <= si_q + 1'b1;
            end else sj_q <= sj_q + 1'b1;
          end else begin
            walk_q <= better ? pi_q : br_q;
          end
        end
        ST_FIND_A: if (at_root) begin
          ra_q <= walk_q;
          parent_q[br_q] <= walk_q;   // path compression of the start node
          walk_q <= bc_q;
        end else walk_q <= parent_q[walk_q];
        ST_FIND_B: if (at_root) begin
          rb_q <= walk_q;
          parent_q[bc_q] <= walk_q;
        end else walk_q <= parent_q[walk_q];
        ST_JOIN: begin
          picked_q <= 1'b1; pick_w_q <= best_q; pick_r_q <= br_q; pick_c_q <= bc_q;
          si_q <= '0; sj_q <= '0; found_q <= 1'b0;
          if (ra_q != rb_q) begin
            if (rank_q[ra_q] < rank_q[rb_q]) parent_q[ra_q] <= rb_q;
            else begin
              parent_q[rb_q] <= ra_q;
              if (rank_q[ra_q] == rank_q[rb_q] && rank_q[ra_q] != RankMax)
                rank_q[ra_q] <= rank_q[ra_q] + 1'b1;
            end
            cnt_q <= cnt_q + 1'b1;
            sum_q <= sum_q + CostBits'(best_q);
          end
        end
        default: ;
      endcase
    end
  end
  // ST_JOIN compares ra_q against rb_q; walk_q equals rb_q there.

  ap_in_only_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input taken during compute");
  ap_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= n1_q || state_q == ST_LOAD || state_q == ST_INIT)
    else $error("edge count overrun");
  ap_summary_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_result_o && out_ready_i) |=> in_ready_o) else $error("no return to load");
endmodule
